[sv/mht_pkg.sv]
// shared types and constants for the mac host table
package mht_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 256;
	localparam int PROBE_LIMIT = 128;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);
	localparam int STEP_W      = $clog2(PROBE_LIMIT + 2);

	// field widths
	localparam int MAC_W  = 48;
	localparam int KIND_W = 2;
	localparam int DBM_W  = 8;
	localparam int SIG_W  = 15;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 8;
	localparam int HASH_W = 16;

	// reciprocal of the slot count for the home slot modulo, scaled by 2^32
	localparam longint unsigned HASH_MUL_L =
		((64'd1 << 32) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
	localparam logic [31:0] HASH_MUL = 32'(HASH_MUL_L);

	// one table entry as held in memory
	typedef struct packed {
		logic                     valid;
		logic [MAC_W-1:0]         mac;
		logic [KIND_W-1:0]        kind;
		logic signed [SIG_W-1:0]  sig;
		logic [TIME_W-1:0]        seen;
	} slot_t;

endpackage

[sv/mac_host_table_with_rssi_smoothing.sv]
// top level: mac host table with linear probing and signal smoothing
//
// Frame channel (frame_valid/frame_ready) carries one observed frame:
// station_mac, host_kind, signal_dbm, now_seconds. Result channel
// (result_valid/result_ready) returns slot_index, was_new, evicted_other and
// smoothed_signal, one result per frame, in order.
// The table lives in one synchronous memory with a registered read. The home
// slot is the low 16 mac bits modulo the slot count, then linear probing
// reads one slot per cycle until an empty slot, a matching mac, or the probe
// limit forces the slot reached.
// After acceptance a frame passes the hash, home read, probe and update steps
// before result_valid rises; the slots read number 1 on a direct hit and at most
// PROBE_LIMIT + 2, and one frame is in work at a time.
// After reset the memory is swept clear, one slot per cycle through all
// TABLE_SLOTS (256) slots, before frame_ready rises.
// The result sits in an output register: the next frame is accepted while
// it waits, and that frame holds in its last step until result_ready frees
// the register.
module mac_host_table_with_rssi_smoothing (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                frame_valid,
	output logic                                frame_ready,
	input  logic [mht_pkg::MAC_W-1:0]           station_mac,
	input  logic [mht_pkg::KIND_W-1:0]          host_kind,
	input  logic signed [mht_pkg::DBM_W-1:0]    signal_dbm,
	input  logic [mht_pkg::TIME_W-1:0]          now_seconds,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [mht_pkg::SLOT_W-1:0]          slot_index,
	output logic                                was_new,
	output logic                                evicted_other,
	output logic signed [mht_pkg::SIG_W-1:0]    smoothed_signal
);

	localparam int IDX_W  = mht_pkg::IDX_W;
	localparam int STEP_W = mht_pkg::STEP_W;

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_HOME  = 3'd3;
	localparam logic [2:0] ST_LOOK  = 3'd4;
	localparam logic [2:0] ST_CALC  = 3'd5;

	localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(mht_pkg::TABLE_SLOTS - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mht_pkg::PROBE_LIMIT);

	logic [2:0]                          state_q;
	logic [IDX_W-1:0]                    clr_q;
	logic [IDX_W-1:0]                    idx_q;
	logic [STEP_W-1:0]                   steps_q;
	logic                                force_q;
	logic [mht_pkg::MAC_W-1:0]           mac_q;
	logic [mht_pkg::KIND_W-1:0]          kind_q;
	logic signed [mht_pkg::DBM_W-1:0]    dbm_q;
	logic [mht_pkg::TIME_W-1:0]          now_q;
	logic [mht_pkg::HASH_W-1:0]          quot_s1;
	logic signed [mht_pkg::SIG_W-1:0]    old_sig_q;
	logic                                new_q;
	logic                                evict_q;

	logic                                out_valid_q;
	logic [mht_pkg::SLOT_W-1:0]          out_slot_q;
	logic                                out_new_q;
	logic                                out_evict_q;
	logic signed [mht_pkg::SIG_W-1:0]    out_sig_q;

	// table memory
	mht_pkg::slot_t                      mem [mht_pkg::TABLE_SLOTS];
	mht_pkg::slot_t                      rd_q;
	mht_pkg::slot_t                      wr_data;
	logic                                rd_en;
	logic [IDX_W-1:0]                    rd_addr;
	logic                                mem_we;
	logic [IDX_W-1:0]                    wr_addr;

	logic                                frame_acc;
	logic                                out_free;
	logic [47:0]                         hash_prod;
	logic [31:0]                         home_mul;
	logic [mht_pkg::HASH_W-1:0]          home_rem;
	logic [IDX_W-1:0]                    home_idx;
	logic [IDX_W-1:0]                    idx_nxt;
	logic                                mac_hit;
	logic                                stop;
	logic signed [mht_pkg::SIG_W-1:0]    new_sig;

	assign frame_ready = (state_q == ST_IDLE);
	assign frame_acc   = frame_valid && frame_ready;
	assign out_free    = !out_valid_q || result_ready;

	// home slot: reciprocal multiply, then remainder
	assign hash_prod = 48'(mac_q[mht_pkg::HASH_W-1:0]) * 48'(mht_pkg::HASH_MUL);
	assign home_mul  = 32'(quot_s1) * 32'(mht_pkg::TABLE_SLOTS);
	assign home_rem  = mac_q[mht_pkg::HASH_W-1:0] - home_mul[mht_pkg::HASH_W-1:0];
	assign home_idx  = home_rem[IDX_W-1:0];

	// next probe slot with wraparound
	assign idx_nxt = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	// probe ends on an empty slot, a matching mac, or a forced takeover
	assign mac_hit = (rd_q.mac == mac_q);
	assign stop    = !rd_q.valid || mac_hit || force_q;

	// memory read port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_nxt;
		if (state_q == ST_HOME) begin
			rd_en   = 1'b1;
			rd_addr = home_idx;
		end else if (state_q == ST_LOOK && !stop) begin
			rd_en   = 1'b1;
		end
	end

	// memory write port: clearing sweep or entry update
	always_comb begin
		mem_we          = 1'b0;
		wr_addr         = idx_q;
		wr_data         = '0;
		if (state_q == ST_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
		end else if (state_q == ST_CALC && out_free) begin
			mem_we        = 1'b1;
			wr_data.valid = 1'b1;
			wr_data.mac   = mac_q;
			wr_data.kind  = kind_q;
			wr_data.sig   = new_sig;
			wr_data.seen  = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// smoothing arithmetic
	mht_smooth u_smooth (
		.old_signal (old_sig_q),
		.dbm        (dbm_q),
		.new_signal (new_sig)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			steps_q <= '0;
			force_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (frame_acc) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_HOME;
				end
				ST_HOME: begin
					idx_q   <= home_idx;
					steps_q <= '0;
					force_q <= 1'b0;
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (stop) begin
						state_q <= ST_CALC;
					end else begin
						idx_q   <= idx_nxt;
						steps_q <= steps_q + 1'b1;
						force_q <= (steps_q == LAST_STEP);
					end
				end
				ST_CALC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// frame capture, home quotient and probe outcome
	always_ff @(posedge clk) begin
		if (frame_acc) begin
			mac_q  <= station_mac;
			kind_q <= host_kind;
			dbm_q  <= signal_dbm;
			now_q  <= now_seconds;
		end
		if (state_q == ST_HASH) begin
			quot_s1 <= hash_prod[47:32];
		end
		if (state_q == ST_LOOK && stop) begin
			old_sig_q <= rd_q.valid ? rd_q.sig : '0;
			new_q     <= !rd_q.valid;
			evict_q   <= rd_q.valid && !mac_hit;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_CALC && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && out_free) begin
			out_slot_q  <= mht_pkg::SLOT_W'(idx_q);
			out_new_q   <= new_q;
			out_evict_q <= evict_q;
			out_sig_q   <= new_sig;
		end
	end

	assign result_valid    = out_valid_q;
	assign slot_index      = out_slot_q;
	assign was_new         = out_new_q;
	assign evicted_other   = out_evict_q;
	assign smoothed_signal = out_sig_q;

	// checks
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |=> !frame_ready)
		else $error("frame accepted while another is in work");

	// the forced takeover slot sits one step past the limit
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> (steps_q <= LAST_STEP + 1'b1))
		else $error("probe ran past the limit");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("memory read and write in the same cycle");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == ST_CALC))
		else $error("result raised outside the update step");

endmodule

[sv/mht_smooth.sv]
// signal smoothing: load -dbm*100 into an empty signal, else old*9/10 - dbm*10
module mht_smooth (
	input  logic signed [mht_pkg::SIG_W-1:0] old_signal,
	input  logic signed [mht_pkg::DBM_W-1:0] dbm,
	output logic signed [mht_pkg::SIG_W-1:0] new_signal
);

	// ceil(2^24 / 10): exact floor division by ten for magnitudes below 2^22
	localparam logic [20:0] DIV10_MUL = 21'd1677722;
	localparam int          DIV10_SH  = 24;

	logic signed [18:0] times9;
	logic [17:0]        mag;
	logic [41:0]        prod;
	logic [17:0]        quo;
	logic signed [19:0] quo_s;
	logic signed [19:0] dbm10;
	logic signed [19:0] dbm100;

	// old * 9 as shift and add
	assign times9 = (19'(old_signal) <<< 3) + 19'(old_signal);

	// truncating divide by ten on the magnitude, sign restored after
	assign mag   = times9[18] ? 18'(-times9) : 18'(times9);
	assign prod  = 42'(mag) * 42'(DIV10_MUL);
	assign quo   = prod[DIV10_SH+17:DIV10_SH];
	assign quo_s = times9[18] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

	assign dbm10  = 20'(dbm) * 20'sd10;
	assign dbm100 = 20'(dbm) * 20'sd100;

	// a stored zero counts as unset
	always_comb begin
		if (old_signal == '0) begin
			new_signal = mht_pkg::SIG_W'(-dbm100);
		end else begin
			new_signal = mht_pkg::SIG_W'(quo_s - dbm10);
		end
	end

endmodule

[tb/mac_host_table_with_rssi_smoothing_tb.sv]
// testbench for the mac host table: random and directed frames checked against a local table model
module mac_host_table_with_rssi_smoothing_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 8;
	localparam int LONG_HOLD    = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 600000;

	// one expected lookup outcome
	typedef struct {
		logic [mht_pkg::SLOT_W-1:0]        slot;
		logic                              fresh;
		logic                              evicted;
		logic signed [mht_pkg::SIG_W-1:0]  level;
	} lookup_result_t;

	// table model plus the queue of outcomes still owed by the block
	class host_table_scoreboard;
		logic                              slot_used [mht_pkg::TABLE_SLOTS];
		logic [mht_pkg::MAC_W-1:0]         slot_owner [mht_pkg::TABLE_SLOTS];
		logic [mht_pkg::KIND_W-1:0]        slot_kind [mht_pkg::TABLE_SLOTS];
		int                                slot_level [mht_pkg::TABLE_SLOTS];
		logic [mht_pkg::TIME_W-1:0]        slot_seen [mht_pkg::TABLE_SLOTS];
		lookup_result_t                    pending_results [$];
		int                                mismatches;

		function new();
			for (int i = 0; i < mht_pkg::TABLE_SLOTS; i++) begin
				slot_used[i]  = 1'b0;
				slot_owner[i] = '0;
				slot_kind[i]  = '0;
				slot_level[i] = 0;
				slot_seen[i]  = '0;
			end
			mismatches = 0;
		endfunction

		function void flag(string what, int want, int got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		// probe the table, smooth the level and queue the outcome
		function void note_frame(logic [mht_pkg::MAC_W-1:0] mac,
				logic [mht_pkg::KIND_W-1:0] kind, logic signed [mht_pkg::DBM_W-1:0] dbm,
				logic [mht_pkg::TIME_W-1:0] stamp);
			int idx;
			int hops;
			int level;
			int dbm_i;
			lookup_result_t outcome;
			idx   = int'(mac[mht_pkg::HASH_W-1:0]) % mht_pkg::TABLE_SLOTS;
			hops  = 0;
			dbm_i = int'(dbm);
			// linear probe, forced stop once the limit is passed
			while (slot_used[idx] && slot_owner[idx] != mac) begin
				idx = (idx + 1) % mht_pkg::TABLE_SLOTS;
				hops++;
				if (hops > mht_pkg::PROBE_LIMIT)
					break;
			end
			level = slot_level[idx];
			// a zero level counts as unset
			if (level == 0)
				level = -dbm_i * 100;
			else
				level = (level * 9) / 10 - dbm_i * 10;
			outcome.slot    = mht_pkg::SLOT_W'(idx);
			outcome.fresh   = !slot_used[idx];
			outcome.evicted = slot_used[idx] && slot_owner[idx] != mac;
			outcome.level   = mht_pkg::SIG_W'(level);
			pending_results.push_back(outcome);
			slot_used[idx]  = 1'b1;
			slot_owner[idx] = mac;
			slot_kind[idx]  = kind;
			slot_seen[idx]  = stamp;
			slot_level[idx] = level;
		endfunction

		// compare one returned outcome with the oldest one owed
		function void check_result(logic [mht_pkg::SLOT_W-1:0] slot, logic fresh,
				logic evicted, logic signed [mht_pkg::SIG_W-1:0] level);
			lookup_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got slot %0d", $time, slot);
				return;
			end
			want = pending_results.pop_front();
			if (slot !== want.slot)
				flag("slot_index", want.slot, slot);
			if (fresh !== want.fresh)
				flag("was_new", want.fresh, fresh);
			if (evicted !== want.evicted)
				flag("evicted_other", want.evicted, evicted);
			if (level !== want.level)
				flag("smoothed_signal", want.level, level);
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               frame_valid;
	logic                               frame_ready;
	logic [mht_pkg::MAC_W-1:0]          station_mac;
	logic [mht_pkg::KIND_W-1:0]         host_kind;
	logic signed [mht_pkg::DBM_W-1:0]   signal_dbm;
	logic [mht_pkg::TIME_W-1:0]         now_seconds;
	logic                               result_valid;
	logic                               result_ready;
	logic [mht_pkg::SLOT_W-1:0]         slot_index;
	logic                               was_new;
	logic                               evicted_other;
	logic signed [mht_pkg::SIG_W-1:0]   smoothed_signal;

	host_table_scoreboard board = new();
	logic [mht_pkg::MAC_W-1:0] known_macs [$];
	logic [mht_pkg::MAC_W-1:0] flood_macs [$];
	bit steady = 1'b0;
	bit hold_request = 1'b0;

	mac_host_table_with_rssi_smoothing DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_valid     (frame_valid),
		.frame_ready     (frame_ready),
		.station_mac     (station_mac),
		.host_kind       (host_kind),
		.signal_dbm      (signal_dbm),
		.now_seconds     (now_seconds),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.slot_index      (slot_index),
		.was_new         (was_new),
		.evicted_other   (evicted_other),
		.smoothed_signal (smoothed_signal)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// transaction monitors on both channels
	always @(posedge clk) begin
		if (arst_n && frame_valid && frame_ready)
			board.note_frame(station_mac, host_kind, signal_dbm, now_seconds);
		if (arst_n && result_valid && result_ready)
			board.check_result(slot_index, was_new, evicted_other, smoothed_signal);
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [mht_pkg::MAC_W-1:0] random_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// result side: ready runs and stalls, plus one long hold on request
	initial begin : result_sink
		int run_len;
		int stall_len;
		result_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end
			run_len = $urandom_range(1, 24);
			result_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = steady ? 0 : idle_length();
			if (stall_len > 0) begin
				result_ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// offer one frame and hold it until the transaction completes
	task automatic offer_frame(input logic [mht_pkg::MAC_W-1:0] mac,
			input logic [mht_pkg::KIND_W-1:0] kind,
			input logic signed [mht_pkg::DBM_W-1:0] dbm,
			input logic [mht_pkg::TIME_W-1:0] stamp);
		int gap;
		frame_valid <= 1'b1;
		station_mac <= mac;
		host_kind   <= kind;
		signal_dbm  <= dbm;
		now_seconds <= stamp;
		do @(posedge clk); while (!frame_ready);
		known_macs.push_back(mac);
		gap = steady ? 0 : idle_length();
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering until every owed result is back
	task automatic drain_results();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	// repeat visits, home-slot collisions and fresh stations
	task automatic send_mixed(input int count);
		logic [mht_pkg::MAC_W-1:0] mac;
		int pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			mac  = random_mac();
			if (known_macs.size() != 0 && pick < 60)
				mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
			else if (known_macs.size() != 0 && pick < 85)
				mac[7:0] = known_macs[$urandom_range(0, known_macs.size() - 1)][7:0];
			offer_frame(mac, mht_pkg::KIND_W'($urandom_range(0, 3)),
				mht_pkg::DBM_W'($urandom_range(0, 255)), $urandom);
		end
	endtask

	// pile stations onto one home slot until the probe limit forces evictions
	task automatic send_flood(input int count);
		logic [7:0] home;
		logic [mht_pkg::MAC_W-1:0] mac;
		home = 8'($urandom_range(0, 255));
		flood_macs.delete();
		repeat (count) begin
			mac = random_mac();
			mac[7:0] = home;
			flood_macs.push_back(mac);
			offer_frame(mac, mht_pkg::KIND_W'($urandom_range(0, 3)),
				mht_pkg::DBM_W'($urandom_range(0, 255)), $urandom);
		end
		// the last three stations come back, the one at the limit slot without evicting
		for (int i = 1; i <= 3; i++)
			offer_frame(flood_macs[count - i], mht_pkg::KIND_W'($urandom_range(0, 3)),
				mht_pkg::DBM_W'($urandom_range(0, 255)), $urandom);
		repeat (17)
			offer_frame(flood_macs[$urandom_range(0, count - 1)],
				mht_pkg::KIND_W'($urandom_range(0, 3)),
				mht_pkg::DBM_W'($urandom_range(0, 255)), $urandom);
	endtask

	// main sequence
	initial begin : stimulus
		arst_n      <= 1'b0;
		frame_valid <= 1'b0;
		station_mac <= '0;
		host_kind   <= '0;
		signal_dbm  <= '0;
		now_seconds <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// extremes; zero level stays unset and reloads
		offer_frame(48'h0, 2'd0, 8'sd0, 32'h0);
		offer_frame(48'h0, 2'd0, -8'sd128, 32'h1);
		offer_frame(48'hFFFF_FFFF_FFFF, 2'd3, 8'sd127, 32'hFFFF_FFFF);
		offer_frame(48'hFFFF_FFFF_FFFF, 2'd3, -8'sd128, 32'hFFFF_FFFE);
		// level that smooths to exactly zero, then reloads
		offer_frame(48'h0123_4567_89AB, 2'd0, -8'sd1, 32'h10);
		offer_frame(48'h0123_4567_89AB, 2'd0, 8'sd9, 32'h11);
		offer_frame(48'h0123_4567_89AB, 2'd0, 8'sd5, 32'h12);
		// collisions on the same home slot, host kinds 1 and 2
		offer_frame(48'hA5A5_A5A5_00AB, 2'd1, -8'sd60, 32'h20);
		offer_frame(48'h5A5A_5A5A_77AB, 2'd2, -8'sd45, 32'h21);
		offer_frame(48'hA5A5_A5A5_00AB, 2'd1, -8'sd70, 32'h22);
		// home slot at the top wraps to the bottom
		offer_frame(48'h8000_0000_12FF, 2'd2, -8'sd90, 32'h30);
		offer_frame(48'h7FFF_FFFF_34FF, 2'd1, -8'sd30, 32'h31);
		offer_frame(48'h8000_0000_12FF, 2'd0, -8'sd88, 32'h32);
		drain_results();

		send_mixed(150);
		drain_results();

		send_flood(136);
		drain_results();

		// long hold on the result side while frames keep coming
		hold_request = 1'b1;
		steady = 1'b1;
		send_mixed(30);
		steady = 1'b0;
		send_mixed(100);
		drain_results();

		// a stretch with no idling on either side, then traffic with gaps again
		steady = 1'b1;
		send_mixed(40);
		steady = 1'b0;
		send_mixed(60);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending_results.size() != 0)
			$display("%0t: results missing, expected %0d more, got 0", $time,
				board.pending_results.size());
		if (board.mismatches == 0 && board.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
